// ===== rtl/hpt_pkg.sv =====
// Shared constants, types and codes of the hashed page table fault fill block.
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;
	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int LINK_W = IDX_W + 1;
	localparam int PAGE_W = 20;
	localparam int SPACE_W = 8;
	localparam int FRAME_W = 20;

	typedef enum logic [2:0] {
		ST_HIT, ST_FILLED, ST_READONLY, ST_BADTYPE,
		ST_BADADDR, ST_FULL, ST_NOFRAME, ST_RESET
	} status_t;

	typedef enum logic [1:0] {
		KIND_READ, KIND_WRITE, KIND_RO, KIND_BAD
	} kind_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_WALK, S_SCAN, S_FILL, S_LINK, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		SRC_NONE, SRC_HIT, SRC_FILL
	} res_src_t;

	typedef struct packed {
		logic               valid;
		logic [SPACE_W-1:0] space;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		logic               dirty;
		logic [LINK_W-1:0]  link;
	} entry_t;

	typedef struct packed {
		logic     load;
		logic     clr_start;
		logic     clr_step;
		logic     walk_step;
		logic     walk_next;
		logic     scan_start;
		logic     scan_next;
		logic     fill_wr;
		logic     link_wr;
		logic     res_load;
		status_t  res_status;
		res_src_t res_src;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic  is_reset;
		kind_t kind;
		logic  region;
		logic  frame_ok;
		logic  rd_valid;
		logic  rd_match;
		logic  link_end;
		logic  steps_last;
		logic  scan_last;
		logic  pred_eq_free;
		logic  clr_last;
	} dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/hpt_in_if.sv =====
// Fault request channel.
`timescale 1ns / 1ps
`default_nettype none
interface hpt_in_if
	import hpt_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [1:0]         fault_kind;
	logic [SPACE_W-1:0] space_id;
	logic [PAGE_W-1:0]  page_number;
	logic               in_region;
	logic               region_writable;
	logic [FRAME_W-1:0] free_frame;
	logic               frame_ok;

	modport source (output valid, cmd, fault_kind, space_id, page_number, in_region,
		region_writable, free_frame, frame_ok, input ready);
	modport sink (input valid, cmd, fault_kind, space_id, page_number, in_region,
		region_writable, free_frame, frame_ok, output ready);
endinterface
`default_nettype wire

// ===== rtl/hpt_out_if.sv =====
// Fault response channel.
`timescale 1ns / 1ps
`default_nettype none
interface hpt_out_if
	import hpt_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [FRAME_W-1:0] frame;
	logic               dirty;
	logic [IDX_W-1:0]   slot;

	modport source (output valid, status, frame, dirty, slot, input ready);
	modport sink (input valid, status, frame, dirty, slot, output ready);
endinterface
`default_nettype wire

// ===== rtl/hashed_page_table_fault_fill_core.sv =====
// Top level of the hashed page table fault fill block.
//
//  channel  dir  word
//  req      in   cmd, fault_kind, space_id, page_number, in_region,
//                region_writable, free_frame, frame_ok
//  rsp      out  status, frame, dirty, slot
//
// A word occupies the block from accept to next accept. A rejected kind only loads
// its result, a hit or bad address walks the hash chain, and a fill also scans for
// a free slot, one table read a cycle on the single memory port. A reset command
// or arst_n sweeps the table, one entry a cycle, while req is held off. A waiting
// rsp word holds the next result in the result registers, with the controller
// waiting in S_DONE, until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module hashed_page_table_fault_fill_core
	import hpt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	hpt_in_if.sink     req,
	hpt_out_if.source  rsp
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	hpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hpt_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_cmd      (req.cmd),
		.in_kind     (req.fault_kind),
		.in_space    (req.space_id),
		.in_page     (req.page_number),
		.in_region   (req.in_region),
		.in_writable (req.region_writable),
		.in_frame    (req.free_frame),
		.in_frame_ok (req.frame_ok),
		.out_status  (rsp.status),
		.out_frame   (rsp.frame),
		.out_dirty   (rsp.dirty),
		.out_slot    (rsp.slot)
	);
endmodule
`default_nettype wire

// ===== rtl/hpt_dpath.sv =====
// Datapath: table memory, walk and scan pointers, result and output registers.
`timescale 1ns / 1ps
`default_nettype none
module hpt_dpath
	import hpt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_stat_t                stat,
	input  wire logic               in_cmd,
	input  wire logic [1:0]         in_kind,
	input  wire logic [SPACE_W-1:0] in_space,
	input  wire logic [PAGE_W-1:0]  in_page,
	input  wire logic               in_region,
	input  wire logic               in_writable,
	input  wire logic [FRAME_W-1:0] in_frame,
	input  wire logic               in_frame_ok,
	output logic [2:0]              out_status,
	output logic [FRAME_W-1:0]      out_frame,
	output logic                    out_dirty,
	output logic [IDX_W-1:0]        out_slot
);
	entry_t             mem_q [TABLE_ENTRIES];
	entry_t             rd_q;
	entry_t             pred_word_q;
	logic [SPACE_W-1:0] space_q;
	logic [PAGE_W-1:0]  page_q;
	logic [FRAME_W-1:0] frame_q;
	logic               writable_q;
	logic               region_q;
	logic               frame_ok_q;
	logic [IDX_W-1:0]   hash_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   steps_q;
	logic [IDX_W-1:0]   pred_q;
	logic [IDX_W-1:0]   scan_q;
	logic [IDX_W-1:0]   clr_q;
	status_t            res_status_q;
	logic [FRAME_W-1:0] res_frame_q;
	logic               res_dirty_q;
	logic [IDX_W-1:0]   res_slot_q;
	logic [IDX_W-1:0]   hash_in;
	logic [IDX_W-1:0]   link_idx;
	logic [IDX_W-1:0]   rd_addr;
	logic               rd_en;
	logic [PAGE_W-1:0]  mix;

	assign mix      = {{(PAGE_W - SPACE_W){1'b0}}, in_space} ^ in_page;
	assign hash_in  = mix[IDX_W-1:0];
	assign link_idx = rd_q.link[IDX_W-1:0] - IDX_W'(1);
	assign rd_en    = cmd.load | cmd.walk_next | cmd.scan_start | cmd.scan_next;

	always_comb begin
		priority if (cmd.load) begin
			rd_addr = hash_in;
		end else if (cmd.walk_next) begin
			rd_addr = link_idx;
		end else if (cmd.scan_start) begin
			rd_addr = hash_q;
		end else begin
			rd_addr = scan_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
		priority if (cmd.clr_step) begin
			mem_q[clr_q] <= '0;
		end else if (cmd.fill_wr) begin
			mem_q[scan_q] <= '{valid: 1'b1, space: space_q, page: page_q, frame: frame_q,
				dirty: writable_q, link: rd_q.link};
		end else if (cmd.link_wr) begin
			mem_q[pred_q] <= '{valid: pred_word_q.valid, space: pred_word_q.space,
				page: pred_word_q.page, frame: pred_word_q.frame, dirty: pred_word_q.dirty,
				link: LINK_W'(scan_q) + LINK_W'(1)};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			space_q    <= in_space;
			page_q     <= in_page;
			frame_q    <= in_frame;
			writable_q <= in_writable;
			region_q   <= in_region;
			frame_ok_q <= in_frame_ok;
			hash_q     <= hash_in;
		end
		if (cmd.walk_step) begin
			pred_q      <= idx_q;
			pred_word_q <= rd_q;
		end
		if (cmd.load) begin
			idx_q   <= hash_in;
			steps_q <= '0;
		end else if (cmd.walk_next) begin
			idx_q   <= link_idx;
			steps_q <= steps_q + IDX_W'(1);
		end
		if (cmd.scan_start) begin
			scan_q <= hash_q;
		end else if (cmd.scan_next) begin
			scan_q <= scan_q + IDX_W'(1);
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			unique case (cmd.res_src)
				SRC_HIT: begin
					res_frame_q <= rd_q.frame;
					res_dirty_q <= rd_q.dirty;
					res_slot_q  <= idx_q;
				end
				SRC_FILL: begin
					res_frame_q <= frame_q;
					res_dirty_q <= writable_q;
					res_slot_q  <= scan_q;
				end
				default: begin
					res_frame_q <= '0;
					res_dirty_q <= 1'b0;
					res_slot_q  <= '0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_status <= res_status_q;
			out_frame  <= res_frame_q;
			out_dirty  <= res_dirty_q;
			out_slot   <= res_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_start) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	always_comb begin
		stat.is_reset     = in_cmd;
		stat.kind         = kind_t'(in_kind);
		stat.region       = region_q;
		stat.frame_ok     = frame_ok_q;
		stat.rd_valid     = rd_q.valid;
		stat.rd_match     = (rd_q.space == space_q) && (rd_q.page == page_q);
		stat.link_end     = (rd_q.link == '0) || (rd_q.link > LINK_W'(TABLE_ENTRIES));
		stat.steps_last   = steps_q == IDX_W'(TABLE_ENTRIES - 1);
		stat.scan_last    = scan_q == IDX_W'(TABLE_ENTRIES - 1);
		stat.pred_eq_free = pred_q == scan_q;
		stat.clr_last     = clr_q == IDX_W'(TABLE_ENTRIES - 1);
	end
endmodule
`default_nettype wire

// ===== rtl/hpt_ctrl.sv =====
// Controller: sequences clearing, chain walk, free-slot scan, fill and response.
`timescale 1ns / 1ps
`default_nettype none
module hpt_ctrl
	import hpt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);
	state_t state_q, state_d;
	logic   report_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   out_free;

	assign in_ready  = state_q == S_IDLE;
	assign in_fire   = in_valid & in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (stat.clr_last) state_d = report_q ? S_DONE : S_IDLE;
			S_IDLE: begin
				if (in_fire) begin
					priority if (stat.is_reset) state_d = S_CLEAR;
					else if (stat.kind == KIND_RO || stat.kind == KIND_BAD) state_d = S_DONE;
					else state_d = S_WALK;
				end
			end
			S_WALK: begin
				priority if (stat.rd_valid && stat.rd_match) begin
					state_d = S_DONE;
				end else if (!stat.rd_valid || stat.link_end || stat.steps_last) begin
					state_d = stat.region ? S_SCAN : S_DONE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_SCAN: begin
				priority if (!stat.rd_valid) state_d = stat.frame_ok ? S_FILL : S_DONE;
				else if (stat.scan_last) state_d = S_DONE;
				else state_d = S_SCAN;
			end
			S_FILL: state_d = stat.pred_eq_free ? S_DONE : S_LINK;
			S_LINK: state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_status = ST_HIT;
		cmd.res_src    = SRC_NONE;
		unique case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				if (in_fire) begin
					priority if (stat.is_reset) begin
						cmd.clr_start  = 1'b1;
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_RESET;
					end else if (stat.kind == KIND_RO) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_READONLY;
					end else if (stat.kind == KIND_BAD) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_BADTYPE;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				priority if (stat.rd_valid && stat.rd_match) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_HIT;
					cmd.res_src    = SRC_HIT;
				end else if (!stat.rd_valid || stat.link_end || stat.steps_last) begin
					if (stat.region) begin
						cmd.scan_start = 1'b1;
					end else begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_BADADDR;
					end
				end else begin
					cmd.walk_next = 1'b1;
				end
			end
			S_SCAN: begin
				priority if (!stat.rd_valid) begin
					if (!stat.frame_ok) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_NOFRAME;
					end
				end else if (stat.scan_last) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_FULL;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_FILL: begin
				cmd.fill_wr    = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_FILLED;
				cmd.res_src    = SRC_FILL;
			end
			S_LINK: cmd.link_wr = 1'b1;
			S_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			report_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && stat.is_reset) begin
				report_q <= 1'b1;
			end else if (state_q == S_CLEAR && stat.clr_last) begin
				report_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the hashed page table fault fill block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import hpt_pkg::*;

	typedef struct packed {
		status_t            status;
		logic [FRAME_W-1:0] frame;
		logic               dirty;
		logic [IDX_W-1:0]   slot;
	} xlat_t;

	logic clk;
	logic arst_n;
	hpt_in_if  req();
	hpt_out_if rsp();

	hashed_page_table_fault_fill_core u_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	// shadow table
	bit                 pt_valid [TABLE_ENTRIES];
	bit [SPACE_W-1:0]   pt_space [TABLE_ENTRIES];
	bit [PAGE_W-1:0]    pt_page  [TABLE_ENTRIES];
	bit [FRAME_W-1:0]   pt_frame [TABLE_ENTRIES];
	bit                 pt_dirty [TABLE_ENTRIES];
	bit [LINK_W-1:0]    pt_link  [TABLE_ENTRIES];

	xlat_t expected_xlat[$];
	int    n_errors;
	int    n_words;
	int    n_checked;
	int    status_seen [8];
	bit    quiet;
	int    sink_idle_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic void wipe_table();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			pt_valid[i] = 1'b0;
			pt_link[i] = '0;
		end
	endfunction

	function automatic xlat_t translate_fault(bit cmd, kind_t kind, bit [SPACE_W-1:0] sid,
			bit [PAGE_W-1:0] vpn, bit region, bit wr, bit [FRAME_W-1:0] pfn, bit fok);
		xlat_t r;
		int idx, pred, fs;
		bit hit, found;
		bit [LINK_W-1:0] nxt;
		r = '{status: ST_RESET, frame: '0, dirty: 1'b0, slot: '0};
		hit = 0;
		found = 0;
		if (cmd) begin
			wipe_table();
			return r;
		end
		if (kind == KIND_RO) begin r.status = ST_READONLY; return r; end
		if (kind == KIND_BAD) begin r.status = ST_BADTYPE; return r; end
		idx = int'({12'b0, sid} ^ vpn) % TABLE_ENTRIES;
		pred = idx;
		for (int s = 0; s < TABLE_ENTRIES; s++) begin
			if (!pt_valid[idx]) begin pred = idx; break; end
			if (pt_space[idx] == sid && pt_page[idx] == vpn) begin hit = 1; break; end
			pred = idx;
			nxt = pt_link[idx];
			if (nxt == 0 || nxt - 1 >= TABLE_ENTRIES) break;
			idx = nxt - 1;
		end
		if (hit) begin
			r.status = ST_HIT;
			r.frame = pt_frame[idx];
			r.dirty = pt_dirty[idx];
			r.slot = idx[IDX_W-1:0];
			return r;
		end
		if (!region) begin r.status = ST_BADADDR; return r; end
		fs = int'({12'b0, sid} ^ vpn) % TABLE_ENTRIES;
		for (; fs < TABLE_ENTRIES; fs++)
			if (!pt_valid[fs]) begin found = 1; break; end
		if (!found) begin r.status = ST_FULL; return r; end
		if (!fok) begin r.status = ST_NOFRAME; return r; end
		pt_valid[fs] = 1'b1;
		pt_space[fs] = sid;
		pt_page[fs] = vpn;
		pt_frame[fs] = pfn;
		pt_dirty[fs] = wr;
		if (pred != fs) pt_link[pred] = LINK_W'(fs + 1);
		r.status = ST_FILLED;
		r.frame = pfn;
		r.dirty = wr;
		r.slot = fs[IDX_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		n_errors++;
		$display("mismatch on result %0d: %s got %0h want %0h", n_checked, what, got, want);
	endtask

	task automatic send_word(bit cmd, kind_t kind, bit [SPACE_W-1:0] sid, bit [PAGE_W-1:0] vpn,
			bit region, bit wr, bit [FRAME_W-1:0] pfn, bit fok);
		if (!quiet && $urandom_range(99) < 12) begin
			req.valid <= 1'b0;
			@(posedge clk);
			while (!quiet && $urandom_range(99) < 12) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.fault_kind <= kind;
		req.space_id <= sid;
		req.page_number <= vpn;
		req.in_region <= region;
		req.region_writable <= wr;
		req.free_frame <= pfn;
		req.frame_ok <= fok;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		expected_xlat.push_back(translate_fault(cmd, kind, sid, vpn, region, wr, pfn, fok));
		n_words++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (expected_xlat.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				xlat_t e;
				if (expected_xlat.size() == 0) begin
					report_mismatch("unexpected word", 0, 0);
				end else begin
					e = expected_xlat.pop_front();
					if (rsp.status != e.status) report_mismatch("status", rsp.status, e.status);
					if (rsp.frame != e.frame) report_mismatch("frame", rsp.frame, e.frame);
					if (rsp.dirty != e.dirty) report_mismatch("dirty", rsp.dirty, e.dirty);
					if (rsp.slot != e.slot) report_mismatch("slot", rsp.slot, e.slot);
					status_seen[e.status]++;
				end
				n_checked++;
			end
			rsp.ready <= quiet ? 1'b1 : ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic test_directed();
		send_word(0, KIND_READ, 8'h00, 20'h00000, 1, 1, 20'hFFFFF, 1);
		send_word(0, KIND_READ, 8'h00, 20'h00000, 0, 0, 20'h0, 0);
		send_word(0, KIND_WRITE, 8'hFF, 20'hFFFFF, 1, 0, 20'h12345, 1);
		send_word(0, KIND_READ, 8'hFF, 20'hFFFFF, 0, 1, 20'h0, 1);
		send_word(0, KIND_RO, 8'hAA, 20'h55555, 1, 1, 20'hFFFFF, 1);
		send_word(0, KIND_BAD, 8'h55, 20'hAAAAA, 1, 1, 20'hFFFFF, 1);
		send_word(0, KIND_READ, 8'h12, 20'h00300, 0, 1, 20'h1, 1);
		send_word(0, KIND_READ, 8'h12, 20'h00300, 1, 1, 20'h1, 0);
		// chain three pages onto one hash slot
		send_word(0, KIND_READ, 8'h01, 20'h00400, 1, 1, 20'hA0001, 1);
		send_word(0, KIND_WRITE, 8'h00, 20'h00401, 1, 0, 20'hA0002, 1);
		send_word(0, KIND_READ, 8'h03, 20'h00402, 1, 1, 20'hA0003, 1);
		send_word(0, KIND_READ, 8'h03, 20'h00402, 0, 0, 20'h0, 0);
		send_word(0, KIND_READ, 8'h00, 20'h00401, 0, 0, 20'h0, 0);
		// end of table, no wrap
		send_word(0, KIND_READ, 8'h00, 20'h003FF, 1, 1, 20'hB0000, 1);
		send_word(0, KIND_READ, 8'h01, 20'h003FE, 1, 1, 20'hB0001, 1);
		send_word(0, KIND_READ, 8'h00, 20'h007FF, 1, 0, 20'hB0002, 1);
		send_word(0, KIND_READ, 8'h00, 20'h007FF, 1, 0, 20'hB0002, 0);
		send_word(1, KIND_BAD, 8'hFF, 20'hFFFFF, 1, 1, 20'hFFFFF, 1);
		send_word(0, KIND_READ, 8'h00, 20'h00000, 0, 0, 20'h0, 0);
	endtask

	task automatic test_pause_until_empty();
		send_word(0, KIND_WRITE, 8'h7E, 20'h12345, 1, 1, 20'h54321, 1);
		drain();
		send_word(0, KIND_READ, 8'h7E, 20'h12345, 0, 0, 20'h0, 0);
	endtask

	// cluster half the traffic in the top quarter of the hash range so chains grow and the tail fills up
	task automatic test_random(int count);
		bit [SPACE_W-1:0] sid;
		bit [PAGE_W-1:0] vpn;
		bit [PAGE_W-1:0] seen_vpn[$];
		bit [SPACE_W-1:0] seen_sid[$];
		int k, pick;
		for (int i = 0; i < count; i++) begin
			quiet = (i >= count / 3 && i < count / 2);
			sink_idle_pct = quiet ? 0 : 12;
			pick = $urandom_range(99);
			if (pick < 1) begin
				send_word(1, kind_t'($urandom_range(3)), SPACE_W'($urandom), PAGE_W'($urandom),
					1'($urandom), 1'($urandom), FRAME_W'($urandom), 1'($urandom));
				seen_vpn.delete();
				seen_sid.delete();
				continue;
			end
			if (pick < 40 && seen_vpn.size() != 0) begin
				k = $urandom_range(seen_vpn.size() - 1);
				sid = seen_sid[k];
				vpn = seen_vpn[k];
			end else begin
				sid = SPACE_W'($urandom);
				vpn = PAGE_W'($urandom);
				if ($urandom_range(1)) vpn[9:0] = 10'h3C0 | 10'($urandom_range(63));
			end
			k = $urandom_range(99);
			send_word(0, kind_t'(k < 5 ? KIND_RO : k < 10 ? KIND_BAD : k < 55 ? KIND_READ
				: KIND_WRITE), sid, vpn, $urandom_range(99) < 90, 1'($urandom),
				FRAME_W'($urandom), $urandom_range(99) < 92);
			seen_sid.push_back(sid);
			seen_vpn.push_back(vpn);
		end
	endtask

	initial begin
		n_errors = 0;
		n_words = 0;
		n_checked = 0;
		quiet = 0;
		sink_idle_pct = 12;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = 1'b0;
		req.fault_kind = KIND_READ;
		req.space_id = '0;
		req.page_number = '0;
		req.in_region = 1'b0;
		req.region_writable = 1'b0;
		req.free_frame = '0;
		req.frame_ok = 1'b0;
		rsp.ready = 1'b0;
		wipe_table();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_pause_until_empty();
		test_random(1930);
		drain();
		repeat (100) @(posedge clk);
		$display("%0d words sent, %0d results checked", n_words, n_checked);
		$display("hit %0d fill %0d full %0d noframe %0d badaddr %0d reset %0d",
			status_seen[ST_HIT], status_seen[ST_FILLED], status_seen[ST_FULL],
			status_seen[ST_NOFRAME], status_seen[ST_BADADDR], status_seen[ST_RESET]);
		if (n_errors == 0 && expected_xlat.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== hashed_page_table_fault_fill_core.f =====
rtl/hpt_pkg.sv
rtl/hpt_in_if.sv
rtl/hpt_out_if.sv
rtl/hpt_dpath.sv
rtl/hpt_ctrl.sv
rtl/hashed_page_table_fault_fill_core.sv
dv/tb_top.sv
